FILE: rtl/sta_pkg.sv
//------------------------------------------------------------------------------
// sta_pkg
// shared constants, cordic angle table and the vector stage record
//------------------------------------------------------------------------------
`default_nettype none
package sta_pkg;
  localparam int CoordWidth    = 16;
  localparam int AngleFracBits = 13;
  localparam int DiffWidth     = CoordWidth + 1;
  localparam int CordicSteps   = 32;
  localparam int Prescale      = 58 - CoordWidth;
  // cordic datapath: scaled difference plus gain headroom
  localparam int CwWidth       = DiffWidth + Prescale + 2;
  localparam int AngWidth      = 37;
  localparam int OutWidth      = 16;
  // front stages, cordic preload plus steps, back stages
  localparam int PipeLatency   = 2 + CordicSteps + 1 + 3;
  localparam logic signed [AngWidth-1:0] PiQ32    = 37'sd13493037704;
  localparam logic signed [AngWidth-1:0] TwoPiQ32 = 37'sd26986075409;
  localparam logic [OutWidth-1:0]        OutMax   = 16'd32767;

  typedef logic signed [CwWidth-1:0]   cw_t;
  typedef logic signed [AngWidth-1:0]  ang_t;
  typedef logic signed [DiffWidth-1:0] diff_t;

  // per-item side information carried down the pipeline
  typedef struct packed {
    logic  degen;
    logic  neg;
  } side_t;

  function automatic ang_t step_angle(input logic [5:0] i);
    ang_t r;
    r = '0;
    case (i)
      6'd0:  r = 37'sd3373259426;
      6'd1:  r = 37'sd1991351318;
      6'd2:  r = 37'sd1052175346;
      6'd3:  r = 37'sd534100635;
      6'd4:  r = 37'sd268086748;
      6'd5:  r = 37'sd134174063;
      6'd6:  r = 37'sd67103403;
      6'd7:  r = 37'sd33553749;
      6'd8:  r = 37'sd16777131;
      6'd9:  r = 37'sd8388597;
      6'd10: r = 37'sd4194303;
      default: r = ang_t'(64'sd1 <<< (6'd32 - i));
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/sta_cordic.sv
//------------------------------------------------------------------------------
// sta_cordic
// pipelined vectoring cordic, one register stage per step, angle in q32
//------------------------------------------------------------------------------
`default_nettype none
module sta_cordic import sta_pkg::*; (
  input  wire logic  clk,
  input  wire logic  en,
  input  wire diff_t vx,
  input  wire diff_t vy,
  output ang_t       angle
);
  cw_t  x_r [CordicSteps+1];
  cw_t  y_r [CordicSteps+1];
  ang_t z_r [CordicSteps+1];
  cw_t  sx, sy;

  assign sx = cw_t'(vx) <<< Prescale;
  assign sy = cw_t'(vy) <<< Prescale;

  always_ff @(posedge clk) begin
    if (en) begin
      if (vx < 0) begin
        x_r[0] <= -sx;
        y_r[0] <= -sy;
        z_r[0] <= PiQ32;
      end else begin
        x_r[0] <= sx;
        y_r[0] <= sy;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar g = 0; g < CordicSteps; g++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[g] >= 0) begin
          x_r[g+1] <= x_r[g] + (y_r[g] >>> g);
          y_r[g+1] <= y_r[g] - (x_r[g] >>> g);
          z_r[g+1] <= z_r[g] + step_angle(6'(g));
        end else begin
          x_r[g+1] <= x_r[g] - (y_r[g] >>> g);
          y_r[g+1] <= y_r[g] + (x_r[g] >>> g);
          z_r[g+1] <= z_r[g] - step_angle(6'(g));
        end
      end
    end
  end

  always_comb begin
    angle = z_r[CordicSteps];
    if (angle < 0) angle = angle + TwoPiQ32;
    else if (angle >= TwoPiQ32) angle = angle - TwoPiQ32;
  end
endmodule
`default_nettype wire

FILE: rtl/sta_front.sv
//------------------------------------------------------------------------------
// sta_front
// differences, coincidence test and exact cross-product sign, registered
//------------------------------------------------------------------------------
`default_nettype none
module sta_front import sta_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [6*CoordWidth-1:0] pts,
  output diff_t                       s1x_r, s1y_r, s2x_r, s2y_r, bx_r, by_r,
  output side_t                       side_r
);
  logic signed [CoordWidth-1:0] x1, y1, x2, y2, x3, y3;
  diff_t s1x, s1y, s2x, s2y, bx, by;
  logic signed [2*DiffWidth-1:0] p_r, q_r;
  logic degen_r;
  assign {y3, x3, y2, x2, y1, x1} = pts;
  assign s1x = diff_t'(x2) - diff_t'(x1);
  assign s1y = diff_t'(y2) - diff_t'(y1);
  assign s2x = diff_t'(x3) - diff_t'(x2);
  assign s2y = diff_t'(y3) - diff_t'(y2);
  assign bx  = diff_t'(x3) - diff_t'(x1);
  assign by  = diff_t'(y3) - diff_t'(y1);

  // stage a: differences and products; stage b: compare
  diff_t a_s1x_r, a_s1y_r, a_s2x_r, a_s2y_r, a_bx_r, a_by_r;
  always_ff @(posedge clk) begin
    if (en) begin
      a_s1x_r <= s1x; a_s1y_r <= s1y; a_s2x_r <= s2x; a_s2y_r <= s2y;
      a_bx_r <= bx; a_by_r <= by;
      p_r <= s1x * s2y;
      q_r <= s1y * s2x;
      degen_r <= (bx == 0 && by == 0) || (s1x == 0 && s1y == 0) ||
                 (s2x == 0 && s2y == 0);
      s1x_r <= a_s1x_r; s1y_r <= a_s1y_r; s2x_r <= a_s2x_r; s2y_r <= a_s2y_r;
      bx_r <= a_bx_r; by_r <= a_by_r;
      side_r.degen <= degen_r;
      side_r.neg   <= p_r < q_r;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sta_back.sv
//------------------------------------------------------------------------------
// sta_back
// angle differences, folding, sum and rounding over three stages
//------------------------------------------------------------------------------
`default_nettype none
module sta_back import sta_pkg::*; (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire ang_t          a1,
  input  wire ang_t          a2,
  input  wire ang_t          ab,
  input  wire side_t         side,
  output logic [OutWidth-1:0] angle_r
);
  ang_t d1_r, d2_r, b_r;
  side_t s1_r, s2_r;
  ang_t d1, d2;
  logic [AngWidth:0] r;

  always_comb begin
    d1 = a1 - ab;
    if (d1 < 0) d1 = d1 + TwoPiQ32;
    d2 = a2 - ab;
    if (d2 < 0) d2 = d2 + TwoPiQ32;
  end

  assign r = (b_r + (ang_t'(1) <<< (31 - AngleFracBits))) >>> (32 - AngleFracBits);

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r <= d1;
      d2_r <= d2;
      s1_r <= side;
      b_r  <= ((d1_r > PiQ32) ? TwoPiQ32 - d1_r : d1_r) +
              ((d2_r > PiQ32) ? TwoPiQ32 - d2_r : d2_r);
      s2_r <= s1_r;
      if (s2_r.degen) angle_r <= '0;
      else if (s2_r.neg)
        angle_r <= -((r > OutMax) ? OutMax : r[OutWidth-1:0]);
      else angle_r <= (r > OutMax) ? OutMax : r[OutWidth-1:0];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/signed_turn_angle.sv
//------------------------------------------------------------------------------
// signed_turn_angle
// signed turn angle at the middle of three points, q13 radians
//------------------------------------------------------------------------------
// channel  dir  content
// in_      in   tdata: p1_x p1_y p2_x p2_y p3_x p3_y
// out_     out  tdata: turn_angle, tuser: degenerate
// one transaction per cycle unless the output stalls; stages: 2 front, 33 cordic, 3 back
// the 33 cordic stages set the latency; all stages advance together
// a stall holds the whole pipe; a last output register holds the result
// reset clears only the valid bits
//------------------------------------------------------------------------------
`default_nettype none
module signed_turn_angle import sta_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [6*CoordWidth-1:0] in_tdata,  // p1_x p1_y p2_x p2_y p3_x p3_y
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [OutWidth-1:0]          out_tdata, // turn_angle
  output logic                         out_tuser  // degenerate
);
  logic [PipeLatency-1:0] v_r;
  logic en;
  diff_t s1x, s1y, s2x, s2y, bx, by;
  side_t side_f;
  side_t side_r [CordicSteps+1];
  ang_t a1, a2, ab;
  logic [OutWidth-1:0] ang;
  logic degen_d1_r, degen_d2_r, degen_d3_r;

  assign en = !v_r[PipeLatency-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = v_r[PipeLatency-1];
  assign out_tdata  = ang;
  assign out_tuser  = degen_d3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[PipeLatency-2:0], in_tvalid};
  end

  sta_front u_front (.clk, .en, .pts(in_tdata), .s1x_r(s1x), .s1y_r(s1y),
    .s2x_r(s2x), .s2y_r(s2y), .bx_r(bx), .by_r(by), .side_r(side_f));
  sta_cordic u_c1 (.clk, .en, .vx(s1x), .vy(s1y), .angle(a1));
  sta_cordic u_c2 (.clk, .en, .vx(s2x), .vy(s2y), .angle(a2));
  sta_cordic u_cb (.clk, .en, .vx(bx), .vy(by), .angle(ab));

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_f;
      for (int i = 1; i <= CordicSteps; i++) side_r[i] <= side_r[i-1];
      degen_d1_r <= side_r[CordicSteps].degen;
      degen_d2_r <= degen_d1_r;
      degen_d3_r <= degen_d2_r;
    end
  end

  sta_back u_back (.clk, .en, .a1, .a2, .ab, .side(side_r[CordicSteps]),
    .angle_r(ang));
endmodule
`default_nettype wire

FILE: rtl/sta_checker.sv
//------------------------------------------------------------------------------
// sta_checker
// port-level checks on the result channel and on input ready
//------------------------------------------------------------------------------
`default_nettype none
module sta_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tuser
);
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 16'd0) else $error("degenerate not zero");
  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata != 16'h8000) else $error("angle below range");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("ready low while output empty");
endmodule
bind signed_turn_angle sta_checker u_chk (.clk, .rst_n, .in_tready, .out_tvalid,
  .out_tready, .out_tdata, .out_tuser);
`default_nettype wire
